// ===== rtl/dsa_pkg.sv =====
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared types and constants for the DSA sign / verify engine.
// ----------------------------------------------------------------------------
package dsa_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int CFG_BITS      = 32;
  localparam int ADDR_BITS     = 4;

  localparam logic [1:0] REG_P = 2'd0;
  localparam logic [1:0] REG_Q = 2'd1;
  localparam logic [1:0] REG_G = 2'd2;
  localparam logic [1:0] REG_X = 2'd3;

  localparam logic [CFG_BITS-1:0] RST_P = 32'd23;
  localparam logic [CFG_BITS-1:0] RST_Q = 32'd11;
  localparam logic [CFG_BITS-1:0] RST_G = 32'd4;
  localparam logic [CFG_BITS-1:0] RST_X = 32'd6;

  typedef enum logic [1:0] {
    ALU_DIV,
    ALU_MUL,
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [2:0] {
    A_IDLE,
    A_PREP_A,
    A_DIV_A,
    A_PREP_B,
    A_DIV_B,
    A_MUL,
    A_FIN
  } alu_state_t;

  typedef enum logic [1:0] {
    JOB_POW,
    JOB_INV,
    JOB_ALU
  } job_t;

  typedef enum logic [3:0] {
    ST_Y,
    ST_GK,
    ST_RO,
    ST_KINV,
    ST_HQ,
    ST_XR,
    ST_SUM,
    ST_SO,
    ST_W,
    ST_U1,
    ST_U2,
    ST_A1,
    ST_A2,
    ST_M,
    ST_V
  } step_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_ALU_GO,
    S_ALU_WAIT,
    S_POW_GO,
    S_POW_RED_W,
    S_POW_MUL,
    S_POW_MUL_W,
    S_POW_SQ,
    S_POW_SQ_W,
    S_INV_GO,
    S_INV_NR_W,
    S_INV_LOOP,
    S_INV_DIV_W,
    S_INV_MUL,
    S_INV_MUL_W,
    S_INV_SUB,
    S_INV_SUB_W,
    S_STORE,
    S_OUT
  } state_t;

endpackage

// ===== rtl/dsa_alu.sv =====
// ----------------------------------------------------------------------------
// dsa_alu
// Shared modular unit: restoring divide (quotient and remainder), bit-serial
// modular multiply with operand reduction, and modular add/sub from the inputs.
// ----------------------------------------------------------------------------
module dsa_alu #(
  parameter int W = dsa_pkg::WORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  dsa_pkg::alu_req_t req,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  input  logic [W-1:0]     m,
  output logic             done,
  output logic [W-1:0]     res,
  output logic [W-1:0]     quo
);
  import dsa_pkg::*;

  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] LAST = CW'(W - 1);

  alu_state_t state, state_next;
  alu_op_t    op;
  logic [W-1:0]  ra, rb, rm, dv, dq, rem, acc;
  logic [CW-1:0] cnt;
  logic          phase;

  logic [W:0]   trial, diff, s, sm, sa, sam;
  logic         ge;
  logic [W-1:0] rem_nx, dq_nx, addend, acc_nx, add_res, sub_res;

  always_comb begin
    trial   = {rem, dq[W-1]};
    diff    = trial - {1'b0, dv};
    ge      = trial >= {1'b0, dv};
    rem_nx  = ge ? diff[W-1:0] : trial[W-1:0];
    dq_nx   = {dq[W-2:0], ge};
    addend  = phase ? ra : acc;
    s       = {1'b0, acc} + {1'b0, addend};
    sm      = s - {1'b0, rm};
    acc_nx  = (s >= {1'b0, rm}) ? sm[W-1:0] : s[W-1:0];
    sa      = {1'b0, a} + {1'b0, b};
    sam     = sa - {1'b0, m};
    add_res = (sa >= {1'b0, m}) ? sam[W-1:0] : sa[W-1:0];
    sub_res = (a >= b) ? a - b : a - b + m;
  end

  always_comb begin
    state_next = state;
    case (state)
      A_IDLE: begin
        if (req.start) begin
          case (req.op)
            ALU_DIV: state_next = (b == '0) ? A_FIN : A_DIV_A;
            ALU_MUL: state_next = (m == '0) ? A_FIN : A_PREP_A;
            default: state_next = A_FIN;
          endcase
        end
      end
      A_PREP_A: state_next = (ra >= rm) ? A_DIV_A : A_PREP_B;
      A_DIV_A: begin
        if (cnt == LAST) state_next = (op == ALU_DIV) ? A_FIN : A_PREP_B;
      end
      A_PREP_B: state_next = (rb >= rm) ? A_DIV_B : A_MUL;
      A_DIV_B: begin
        if (cnt == LAST) state_next = A_MUL;
      end
      A_MUL: begin
        if (phase && cnt == LAST) state_next = A_FIN;
      end
      A_FIN:   state_next = A_IDLE;
      default: state_next = A_IDLE;
    endcase
  end

  always_comb begin
    done = (state == A_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      A_IDLE: begin
        if (req.start) begin
          op  <= req.op;
          ra  <= a;
          rb  <= b;
          rm  <= m;
          dq  <= a;
          dv  <= b;
          rem <= '0;
          cnt <= '0;
          case (req.op)
            ALU_DIV: begin
              res <= '0;
              quo <= '0;
            end
            ALU_MUL: res <= '0;
            ALU_ADD: res <= add_res;
            default: res <= sub_res;
          endcase
        end
      end
      A_PREP_A: begin
        dq  <= ra;
        dv  <= rm;
        rem <= '0;
        cnt <= '0;
      end
      A_DIV_A: begin
        rem <= rem_nx;
        dq  <= dq_nx;
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          res <= rem_nx;
          quo <= dq_nx;
          ra  <= rem_nx;
        end
      end
      A_PREP_B: begin
        dq    <= rb;
        dv    <= rm;
        rem   <= '0;
        cnt   <= '0;
        acc   <= '0;
        phase <= 1'b0;
      end
      A_DIV_B: begin
        rem <= rem_nx;
        dq  <= dq_nx;
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          rb    <= rem_nx;
          acc   <= '0;
          cnt   <= '0;
          phase <= 1'b0;
        end
      end
      A_MUL: begin
        if (!phase) begin
          acc   <= acc_nx;
          phase <= 1'b1;
        end else begin
          if (rb[W-1]) acc <= acc_nx;
          rb    <= {rb[W-2:0], 1'b0};
          phase <= 1'b0;
          cnt   <= cnt + 1'b1;
          if (cnt == LAST) res <= rb[W-1] ? acc_nx : acc;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/dsa_sign_verify_engine_core.sv =====
// ----------------------------------------------------------------------------
// dsa_sign_verify_engine_core
// DSA sign / verify request engine built around one shared modular unit.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in      | input     | in_valid / in_ready    | kind, msg_hash, nonce_k,
//           |           |                        | sig_r_in, sig_s_in
//   out     | output    | out_valid / out_ready  | sig_r_out, sig_s_out,
//           |           |                        | check_value, valid_res, public_key
//   cfg     | APB       | psel/penable/pready    | paddr, pwdata, prdata
//
// Each word runs two exponentiations and one inverse to sign, three and one
// to verify, all through the shared unit; a modular multiply first divides
// down any operand that needs reducing. in_ready is high only when idle. The
// result word sits in its own register until out_ready, so the next request
// may start meanwhile. Synchronous reset restores the register defaults.
// ----------------------------------------------------------------------------
module dsa_sign_verify_engine_core #(
  parameter int WORD_BITS = dsa_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            kind,
  input  logic [31:0]                     msg_hash,
  input  logic [31:0]                     nonce_k,
  input  logic [31:0]                     sig_r_in,
  input  logic [31:0]                     sig_s_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [31:0]                     sig_r_out,
  output logic [31:0]                     sig_s_out,
  output logic [31:0]                     check_value,
  output logic                            valid_res,
  output logic [31:0]                     public_key,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dsa_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [dsa_pkg::CFG_BITS-1:0]    pwdata,
  output logic [dsa_pkg::CFG_BITS-1:0]    prdata,
  output logic                            pready
);
  import dsa_pkg::*;

  localparam int W = WORD_BITS;

  logic [CFG_BITS-1:0] reg_p, reg_q, reg_g, reg_x;
  logic [W-1:0] cp, cq, cg, cx;

  state_t state, state_next;
  step_t  step, step_after;
  logic   kind_q;
  logic [W-1:0] h, k, rin, sin;
  logic [W-1:0] y, ro, so, v, w, u1, u2, tmp;
  logic         ok;
  logic [W-1:0] oa, ob, om, acc, base, t, nt, r, nr, qt, rs, sres;
  alu_op_t      aop;

  job_t         job;
  alu_op_t      dop;
  logic [W-1:0] da, db, dm;

  alu_req_t     req;
  logic [W-1:0] alu_a, alu_b, alu_m, alu_res, alu_quo;
  logic         alu_done;

  logic [31:0]  res_r, res_s, res_v, res_y;
  logic         res_ok;
  logic         res_load;

  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_p <= RST_P;
      reg_q <= RST_Q;
      reg_g <= RST_G;
      reg_x <= RST_X;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_P:   reg_p <= pwdata;
        REG_Q:   reg_q <= pwdata;
        REG_G:   reg_g <= pwdata;
        default: reg_x <= pwdata;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_P:   prdata = reg_p;
      REG_Q:   prdata = reg_q;
      REG_G:   prdata = reg_g;
      default: prdata = reg_x;
    endcase
  end

  assign cp = W'(reg_p);
  assign cq = W'(reg_q);
  assign cg = W'(reg_g);
  assign cx = W'(reg_x);

  always_comb begin
    job = JOB_ALU;
    dop = ALU_MUL;
    da  = cg;
    db  = cx;
    dm  = cq;
    case (step)
      ST_Y: begin
        job = JOB_POW; da = cg; db = cx; dm = cp;
      end
      ST_GK: begin
        job = JOB_POW; da = cg; db = k; dm = cp;
      end
      ST_RO: begin
        dop = ALU_DIV; da = tmp; db = cq;
      end
      ST_KINV: begin
        job = JOB_INV; da = k; dm = cq;
      end
      ST_HQ: begin
        dop = ALU_DIV; da = h; db = cq;
      end
      ST_XR: begin
        da = cx; db = ro; dm = cq;
      end
      ST_SUM: begin
        dop = ALU_ADD; da = u1; db = u2; dm = cq;
      end
      ST_SO: begin
        da = w; db = u1; dm = cq;
      end
      ST_W: begin
        job = JOB_INV; da = sin; dm = cq;
      end
      ST_U1: begin
        da = h; db = w; dm = cq;
      end
      ST_U2: begin
        da = rin; db = w; dm = cq;
      end
      ST_A1: begin
        job = JOB_POW; da = cg; db = u1; dm = cp;
      end
      ST_A2: begin
        job = JOB_POW; da = y; db = u2; dm = cp;
      end
      ST_M: begin
        da = tmp; db = u2; dm = cp;
      end
      ST_V: begin
        dop = ALU_DIV; da = tmp; db = cq;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (step)
      ST_Y:    step_after = kind_q ? ST_W : ST_GK;
      ST_GK:   step_after = ST_RO;
      ST_RO:   step_after = ST_KINV;
      ST_KINV: step_after = ST_HQ;
      ST_HQ:   step_after = ST_XR;
      ST_XR:   step_after = ST_SUM;
      ST_SUM:  step_after = ST_SO;
      ST_W:    step_after = ST_U1;
      ST_U1:   step_after = ST_U2;
      ST_U2:   step_after = ST_A1;
      ST_A1:   step_after = ST_A2;
      ST_A2:   step_after = ST_M;
      ST_M:    step_after = ST_V;
      default: step_after = ST_Y;
    endcase
  end

  assign res_load = (state == S_OUT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        case (job)
          JOB_POW: state_next = S_POW_GO;
          JOB_INV: state_next = S_INV_GO;
          default: state_next = S_ALU_GO;
        endcase
      end
      S_ALU_GO:    state_next = S_ALU_WAIT;
      S_ALU_WAIT:  if (alu_done) state_next = S_STORE;
      S_POW_GO:    state_next = (om == '0) ? S_STORE : S_POW_RED_W;
      S_POW_RED_W: begin
        if (alu_done) state_next = (ob == '0) ? S_STORE : S_POW_MUL;
      end
      S_POW_MUL:   state_next = ob[0] ? S_POW_MUL_W : S_POW_SQ;
      S_POW_MUL_W: if (alu_done) state_next = S_POW_SQ;
      S_POW_SQ:    state_next = (ob[W-1:1] == '0) ? S_STORE : S_POW_SQ_W;
      S_POW_SQ_W:  if (alu_done) state_next = S_POW_MUL;
      S_INV_GO:    state_next = (om == '0) ? S_STORE : S_INV_NR_W;
      S_INV_NR_W:  if (alu_done) state_next = S_INV_LOOP;
      S_INV_LOOP:  state_next = (nr == '0) ? S_STORE : S_INV_DIV_W;
      S_INV_DIV_W: if (alu_done) state_next = S_INV_MUL;
      S_INV_MUL:   state_next = S_INV_MUL_W;
      S_INV_MUL_W: if (alu_done) state_next = S_INV_SUB;
      S_INV_SUB:   state_next = S_INV_SUB_W;
      S_INV_SUB_W: if (alu_done) state_next = S_INV_LOOP;
      S_STORE: begin
        state_next = (step == ST_SO || step == ST_V) ? S_OUT : S_DISPATCH;
      end
      S_OUT:       if (res_load) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    req.start = 1'b0;
    req.op    = ALU_DIV;
    alu_a     = oa;
    alu_b     = om;
    alu_m     = om;
    case (state)
      S_ALU_GO: begin
        req.start = 1'b1; req.op = aop; alu_b = ob;
      end
      S_POW_GO:  req.start = (om != '0);
      S_POW_MUL: begin
        req.start = ob[0]; req.op = ALU_MUL; alu_a = acc; alu_b = base;
      end
      S_POW_SQ: begin
        req.start = (ob[W-1:1] != '0); req.op = ALU_MUL; alu_a = base; alu_b = base;
      end
      S_INV_GO:  req.start = (om != '0);
      S_INV_LOOP: begin
        req.start = (nr != '0); alu_a = r; alu_b = nr;
      end
      S_INV_MUL: begin
        req.start = 1'b1; req.op = ALU_MUL; alu_a = qt; alu_b = nt;
      end
      S_INV_SUB: begin
        req.start = 1'b1; req.op = ALU_SUB; alu_a = t; alu_b = qt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          kind_q <= kind;
          h      <= W'(msg_hash);
          k      <= W'(nonce_k);
          rin    <= W'(sig_r_in);
          sin    <= W'(sig_s_in);
          ro     <= '0;
          so     <= '0;
          v      <= '0;
          ok     <= 1'b0;
          step   <= ST_Y;
        end
      end
      S_DISPATCH: begin
        oa  <= da;
        ob  <= db;
        om  <= dm;
        aop <= dop;
      end
      S_ALU_WAIT:  if (alu_done) sres <= alu_res;
      S_POW_GO:    sres <= '0;
      S_POW_RED_W: begin
        if (alu_done) begin
          base <= alu_res;
          acc  <= {{(W-1){1'b0}}, 1'b1};
          sres <= {{(W-1){1'b0}}, 1'b1};
        end
      end
      S_POW_MUL_W: if (alu_done) acc <= alu_res;
      S_POW_SQ: begin
        ob   <= ob >> 1;
        sres <= acc;
      end
      S_POW_SQ_W:  if (alu_done) base <= alu_res;
      S_INV_GO: begin
        sres <= '0;
        t    <= '0;
        nt   <= (om == {{(W-1){1'b0}}, 1'b1}) ? '0 : {{(W-1){1'b0}}, 1'b1};
        r    <= om;
      end
      S_INV_NR_W:  if (alu_done) nr <= alu_res;
      S_INV_LOOP:  sres <= t;
      S_INV_DIV_W: begin
        if (alu_done) begin
          qt <= alu_quo;
          rs <= alu_res;
        end
      end
      S_INV_MUL_W: if (alu_done) qt <= alu_res;
      S_INV_SUB_W: begin
        if (alu_done) begin
          t  <= nt;
          nt <= alu_res;
          r  <= nr;
          nr <= rs;
        end
      end
      S_STORE: begin
        step <= step_after;
        case (step)
          ST_Y:    y   <= sres;
          ST_GK:   tmp <= sres;
          ST_RO:   ro  <= sres;
          ST_KINV: w   <= sres;
          ST_HQ:   u1  <= sres;
          ST_XR:   u2  <= sres;
          ST_SUM:  u1  <= sres;
          ST_SO:   so  <= sres;
          ST_W:    w   <= sres;
          ST_U1:   u1  <= sres;
          ST_U2:   u2  <= sres;
          ST_A1:   tmp <= sres;
          ST_A2:   u2  <= sres;
          ST_M:    tmp <= sres;
          default: begin
            v  <= sres;
            ok <= (sres == rin);
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r  <= 32'(ro);
      res_s  <= 32'(so);
      res_v  <= 32'(v);
      res_ok <= ok;
      res_y  <= 32'(y);
    end
  end

  assign sig_r_out   = res_r;
  assign sig_s_out   = res_s;
  assign check_value = res_v;
  assign valid_res   = res_ok;
  assign public_key  = res_y;

  dsa_alu #(
    .W(W)
  ) u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .a    (alu_a),
    .b    (alu_b),
    .m    (alu_m),
    .done (alu_done),
    .res  (alu_res),
    .quo  (alu_quo)
  );

endmodule

// ===== bench/dsa_sign_verify_engine_core_tb.sv =====
// ----------------------------------------------------------------------------
// dsa_sign_verify_engine_core_tb
// Drives sign and verify words through the engine under several key and group
// settings, predicts each result with an independent modular-arithmetic model
// and checks every returned word in order, with random idling on both sides.
// ----------------------------------------------------------------------------
module dsa_sign_verify_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dsa_pkg::*;

  typedef struct packed {
    logic [31:0] r;
    logic [31:0] s;
    logic [31:0] v;
    logic        ok;
    logic [31:0] y;
  } dsa_word_t;

  class dsa_scoreboard;
    bit [63:0] p, q, g, x;
    dsa_word_t pending[$];
    int errors;

    function new();
      p = 23; q = 11; g = 4; x = 6;
      errors = 0;
    endfunction

    function bit [63:0] modred(bit [63:0] a, bit [63:0] m);
      return (m == 0) ? 64'd0 : a % m;
    endfunction

    function bit [63:0] modmul(bit [63:0] a, bit [63:0] b, bit [63:0] m);
      if (m == 0) return 0;
      return ((a % m) * (b % m)) % m;
    endfunction

    function bit [63:0] modpow(bit [63:0] b, bit [63:0] e, bit [63:0] m);
      bit [63:0] acc;
      acc = 1;
      if (m == 0) return 0;
      b = b % m;
      while (e != 0) begin
        if (e[0]) acc = modmul(acc, b, m);
        e = e >> 1;
        b = modmul(b, b, m);
      end
      return acc;
    endfunction

    function bit [63:0] modinv(bit [63:0] a, bit [63:0] m);
      bit [63:0] t, nt, r, nr, qt, tmp, prod;
      if (m == 0) return 0;
      t = 0; nt = 1 % m; r = m; nr = a % m;
      while (nr != 0) begin
        qt = r / nr;
        prod = modmul(qt, nt, m);
        tmp = (t >= prod) ? t - prod : t + (m - prod);
        t = nt; nt = tmp;
        tmp = r - qt * nr;
        r = nr; nr = tmp;
      end
      return t;
    endfunction

    function void sign(bit [63:0] h, bit [63:0] k, output bit [63:0] r, output bit [63:0] s);
      bit [63:0] sum, hq, xr;
      r = modred(modpow(g, k, p), q);
      if (q == 0) sum = 0;
      else begin
        hq = h % q;
        xr = modmul(x, r, q);
        sum = (hq >= q - xr) ? hq - (q - xr) : hq + xr;
      end
      s = modmul(modinv(k, q), sum, q);
    endfunction

    function void note(bit kd, bit [31:0] h, bit [31:0] k, bit [31:0] rin, bit [31:0] sin);
      dsa_word_t e;
      bit [63:0] r, s, w, u1, u2, v, y;
      y = modpow(g, x, p);
      e = '0;
      e.y = y[31:0];
      if (!kd) begin
        sign(h, k, r, s);
        e.r = r[31:0];
        e.s = s[31:0];
      end else begin
        w = modinv(sin, q);
        u1 = modmul(h, w, q);
        u2 = modmul(rin, w, q);
        v = modred(modmul(modpow(g, u1, p), modpow(y, u2, p), p), q);
        e.v = v[31:0];
        e.ok = (v == {32'd0, rin});
      end
      pending.push_back(e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check(dsa_word_t got);
      dsa_word_t e;
      if (pending.size() == 0) begin
        report("unexpected word", got.r, '0);
        return;
      end
      e = pending.pop_front();
      if (got.r !== e.r) report("sig_r_out", got.r, e.r);
      if (got.s !== e.s) report("sig_s_out", got.s, e.s);
      if (got.v !== e.v) report("check_value", got.v, e.v);
      if (got.ok !== e.ok) report("valid_res", 32'(got.ok), 32'(e.ok));
      if (got.y !== e.y) report("public_key", got.y, e.y);
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_ready;
  logic kind = 0;
  logic [31:0] msg_hash = 0, nonce_k = 0, sig_r_in = 0, sig_s_in = 0;
  logic out_valid, out_ready = 0;
  logic [31:0] sig_r_out, sig_s_out, check_value, public_key;
  logic valid_res;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_BITS-1:0] paddr = 0;
  logic [CFG_BITS-1:0] pwdata = 0, prdata;
  logic pready;

  dsa_scoreboard board = new();
  bit quiet = 0;
  int rx_stall = 0;

  dsa_sign_verify_engine_core dut (.*);

  always #6 clk = ~clk;

  initial begin
    #400000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver with random stall bursts
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        board.check({sig_r_out, sig_s_out, check_value, valid_res, public_key});
      if (rx_stall > 0) begin
        out_ready <= 0;
        rx_stall <= rx_stall - 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready <= 0;
        rx_stall <= $urandom_range(1, 19) - 1;
      end else begin
        out_ready <= 1;
      end
    end
  end

  task reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_P: board.p = val;
      REG_Q: board.q = val;
      REG_G: board.g = val;
      default: board.x = val;
    endcase
  endtask

  task settle();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task set_group(logic [31:0] p, logic [31:0] q, logic [31:0] g, logic [31:0] x);
    settle();
    reg_write(REG_P, p);
    reg_write(REG_Q, q);
    reg_write(REG_G, g);
    reg_write(REG_X, x);
  endtask

  task send(bit kd, logic [31:0] h, logic [31:0] k, logic [31:0] r, logic [31:0] s);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1;
    kind <= kd; msg_hash <= h; nonce_k <= k; sig_r_in <= r; sig_s_in <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note(kd, h, k, r, s);
  endtask

  task send_random(int n);
    bit [63:0] r, s;
    logic [31:0] h, k;
    repeat (n) begin
      h = $urandom; k = $urandom;
      if ($urandom_range(0, 1) == 0) begin
        send(0, h, k, $urandom, $urandom);
      end else if ($urandom_range(0, 9) < 6) begin
        board.sign(h, k, r, s);
        if ($urandom_range(0, 4) == 0) r = r ^ (64'd1 << $urandom_range(0, 31));
        send(1, h, $urandom, r[31:0], s[31:0]);
      end else begin
        send(1, h, k, $urandom, $urandom);
      end
    end
    in_valid <= 0;
  endtask

  initial begin
    bit [63:0] r, s;
    repeat (7) @(posedge clk);
    rst <= 0;
    // directed, reset group p=23 q=11 g=4 x=6
    send(0, 0, 0, 0, 0);
    send(0, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0);
    send(0, 5, 3, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send(0, 9, 11, 0, 0);
    board.sign(9, 3, r, s);
    send(1, 9, 0, r[31:0], s[31:0]);
    send(1, 9, 0, r[31:0] + 1, s[31:0]);
    send(1, 7, 0, 3, 0);
    send(1, 7, 0, 3, 22);
    send(1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send(1, 0, 0, 0, 1);
    in_valid <= 0;
    set_group(2, 2, 0, 0);
    send(0, 32'hFFFFFFFF, 0, 0, 0);
    send(0, 1, 1, 0, 0);
    send(1, 1, 0, 0, 1);
    send(1, 0, 0, 1, 0);
    in_valid <= 0;
    set_group(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send(0, 32'h80000000, 32'hFFFFFFFE, 0, 0);
    send(1, 32'h12345678, 0, 32'h0000FFFF, 6);
    send_random(10);
    set_group(32'hFFFFFFFB, 2147483645, 3, 32'h7FFFFFFF);
    send_random(25);
    set_group(23, 11, 4, 6);
    send_random(25);
    set_group(2, 32'hFFFFFFFF, 32'hFFFFFFFF, 1);
    send_random(15);
    set_group($urandom_range(2, 32'hFFFFFFFF), $urandom_range(2, 32'hFFFFFFFF),
              $urandom, $urandom);
    send_random(25);
    set_group($urandom_range(2, 1000), $urandom_range(2, 1000), $urandom, $urandom);
    send_random(25);
    set_group($urandom_range(2, 32'hFFFFFFFF), $urandom_range(2, 32'hFFFFFFFF),
              $urandom, $urandom);
    quiet = 1;
    send_random(25);
    settle();
    repeat (50) @(posedge clk);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/dsa_pkg.sv
rtl/dsa_alu.sv
rtl/dsa_sign_verify_engine_core.sv
bench/dsa_sign_verify_engine_core_tb.sv
